// ----- rtl/hecs_pkg.sv -----
// Shared constants and helpers for the helium effective-charge pipeline.
// Used by hecs_exp_neg and helium_effective_charge_square; no dependencies.
package hecs_pkg;

  localparam int ENERGY_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  localparam int Z_BITS          = 7;

  // Natural-log constants at 30 fraction bits.
  localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
  localparam logic [63:0] LN2_Q30     = 64'd744261118;
  localparam logic [63:0] LN_MASS_Q30 = 64'd8906365694;

  // Fit coefficients in millionths, constant term first.
  localparam int POLY_MICRO [6] = '{286500, 126600, -1429, 24020, -11350, 1475};

  // Rounds a coefficient in millionths to f fraction bits, half away from zero.
  function automatic longint micro_to_q(input int m, input int f);
    longint mag;
    longint q;
    mag = (m < 0) ? -longint'(m) : longint'(m);
    q   = ((mag << f) + 64'sd500000) / 64'sd1000000;
    return (m < 0) ? -q : q;
  endfunction

endpackage

// ----- rtl/hecs_exp_neg.sv -----
// Pipelined exp(-v) unit: range reduction by ln 2 and a nested Taylor series.
// Depends on hecs_pkg for the ln 2 constant.
module hecs_exp_neg #(
  parameter int FRAC_BITS = hecs_pkg::FRAC_BITS_DEF,
  parameter int SIDE_BITS = 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [FRAC_BITS+12:0] in_arg,
  input  logic [SIDE_BITS-1:0] in_side,
  output logic                 out_vld,
  output logic [FRAC_BITS:0]   out_val,
  output logic [SIDE_BITS-1:0] out_side
);
  import hecs_pkg::*;

  localparam int F    = FRAC_BITS;
  localparam int V30W = F + 13 + 30 - F;
  localparam int KB   = $clog2(F + 2);
  localparam int RW   = 31 + KB;
  localparam int NT   = 14;
  localparam logic [V30W-1:0] LIM = V30W'(64'(F + 2) * LN2_Q30);

  // Range reduction: one quotient bit per stage, index 0 is the entry stage.
  logic                 dv_v_r    [0:KB];
  logic [RW-1:0]        dv_rem_r  [0:KB];
  logic [KB-1:0]        dv_k_r    [0:KB];
  logic                 dv_big_r  [0:KB];
  logic [SIDE_BITS-1:0] dv_side_r [0:KB];

  logic [V30W-1:0] v30;
  assign v30 = {in_arg, (30 - F)'(0)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_v_r[0] <= 1'b0;
    end else if (en) begin
      dv_v_r[0] <= in_vld;
    end
  end

  // A shift of 32 or more leaves nothing after rounding.
  always_ff @(posedge clk) begin
    if (en) begin
      dv_rem_r[0]  <= v30[RW-1:0];
      dv_k_r[0]    <= '0;
      dv_big_r[0]  <= (v30 >= LIM);
      dv_side_r[0] <= in_side;
    end
  end

  for (genvar b = 1; b <= KB; b++) begin : g_div
    logic [RW-1:0] sub;
    logic          ge;
    assign sub = RW'(LN2_Q30) << (KB - b);
    assign ge  = (dv_rem_r[b-1] >= sub);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_v_r[b] <= 1'b0;
      end else if (en) begin
        dv_v_r[b] <= dv_v_r[b-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem_r[b]  <= ge ? dv_rem_r[b-1] - sub : dv_rem_r[b-1];
        dv_k_r[b]    <= dv_k_r[b-1] | (ge ? KB'(1) << (KB - b) : KB'(0));
        dv_big_r[b]  <= dv_big_r[b-1];
        dv_side_r[b] <= dv_side_r[b-1];
      end
    end
  end

  // Taylor series: each term takes a multiply stage and a divide-by-n stage.
  logic                 tl_v_r    [0:2*NT];
  logic [30:0]          tl_t_r    [0:2*NT];
  logic [29:0]          tl_r_r    [0:2*NT];
  logic [KB-1:0]        tl_k_r    [0:2*NT];
  logic                 tl_big_r  [0:2*NT];
  logic [SIDE_BITS-1:0] tl_side_r [0:2*NT];

  assign tl_v_r[0]    = dv_v_r[KB];
  assign tl_t_r[0]    = 31'(Q30_ONE);
  assign tl_r_r[0]    = dv_rem_r[KB][29:0];
  assign tl_k_r[0]    = dv_k_r[KB];
  assign tl_big_r[0]  = dv_big_r[KB];
  assign tl_side_r[0] = dv_side_r[KB];

  for (genvar j = 0; j < NT; j++) begin : g_term
    localparam int N = NT - j;
    // Reciprocal of n, exact for every 30-bit dividend.
    localparam logic [34:0] M = 35'(((64'd1 << 34) + 64'(N) - 64'd1) / 64'(N));
    logic [60:0] rt;
    logic [64:0] pm;
    assign rt = 61'(tl_r_r[2*j]) * 61'(tl_t_r[2*j]);
    assign pm = 65'(tl_t_r[2*j+1][29:0]) * 65'(M);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        tl_v_r[2*j+1] <= 1'b0;
        tl_v_r[2*j+2] <= 1'b0;
      end else if (en) begin
        tl_v_r[2*j+1] <= tl_v_r[2*j];
        tl_v_r[2*j+2] <= tl_v_r[2*j+1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        tl_t_r[2*j+1]    <= {1'b0, rt[59:30]};
        tl_r_r[2*j+1]    <= tl_r_r[2*j];
        tl_k_r[2*j+1]    <= tl_k_r[2*j];
        tl_big_r[2*j+1]  <= tl_big_r[2*j];
        tl_side_r[2*j+1] <= tl_side_r[2*j];
        tl_t_r[2*j+2]    <= 31'(Q30_ONE) - 31'(pm[63:34]);
        tl_r_r[2*j+2]    <= tl_r_r[2*j+1];
        tl_k_r[2*j+2]    <= tl_k_r[2*j+1];
        tl_big_r[2*j+2]  <= tl_big_r[2*j+1];
        tl_side_r[2*j+2] <= tl_side_r[2*j+1];
      end
    end
  end

  // Scale back by 2^-(k + 30 - F), rounding half up.
  logic [5:0]  sh;
  logic [32:0] rnd;
  logic [32:0] shifted;
  assign sh      = 6'(tl_k_r[2*NT]) + 6'(30 - F);
  assign rnd     = 33'(tl_t_r[2*NT]) + (33'd1 << (sh - 6'd1));
  assign shifted = rnd >> sh;

  logic                 out_vld_r;
  logic [F:0]           out_val_r;
  logic [SIDE_BITS-1:0] out_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= tl_v_r[2*NT];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r  <= tl_big_r[2*NT] ? '0 : shifted[F:0];
      out_side_r <= tl_side_r[2*NT];
    end
  end

  assign out_vld  = out_vld_r;
  assign out_val  = out_val_r;
  assign out_side = out_side_r;

endmodule

// ----- rtl/helium_effective_charge_square.sv -----
// Squared effective charge of a helium ion from its energy and the target
// atomic number, as one fully pipelined datapath.
// Depends on hecs_pkg and hecs_exp_neg.
//
// Usage: the input channel carries in_energy_ev (eV) and in_atomic_number;
// a beat is taken at a clock edge with in_valid high and in_stall low. The
// result channel returns out_charge_square, unsigned Q3.FRAC_BITS saturated
// at 5.0, one result beat per input beat and in order.
// Throughput is one beat per cycle while the output is not stalled. The
// pipeline has thirty squaring stages for the binary log, five Horner
// stages, and two exp units of 30 + clog2(FRAC_BITS + 2) stages each
// (range reduction bit by bit and two stages per Taylor term).
// Reset clears all valid bits; no clearing pass is needed.
// While a result beat waits with out_stall high the whole pipeline holds,
// in_stall is raised and nothing is lost or repeated; bubbles in the
// pipeline move on whenever the output register is free.
module helium_effective_charge_square #(
  parameter int ENERGY_BITS = hecs_pkg::ENERGY_BITS_DEF,
  parameter int FRAC_BITS   = hecs_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [ENERGY_BITS-1:0]      in_energy_ev,
  input  logic [hecs_pkg::Z_BITS-1:0] in_atomic_number,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [FRAC_BITS+2:0]        out_charge_square
);
  import hecs_pkg::*;

  localparam int F   = FRAC_BITS;
  localparam int NW  = $clog2(ENERGY_BITS);
  localparam int LW  = F + 4;
  localparam int XW  = F + 14;
  localparam int VW  = F + 13;
  localparam int AW  = F;
  localparam int EXW = F + 1;
  localparam int OW  = F + 3;
  localparam int LNW = 37;
  localparam logic [63:0] ONE  = 64'd1 << F;
  localparam logic [63:0] HALF = 64'd1 << (F - 1);
  localparam logic [63:0] C76  = ((64'd76 << F) + 64'd5) / 64'd10;
  localparam logic [63:0] LMAX = (64'd16 << F) - 64'd1;

  logic adv;
  logic out_valid_r;
  logic [OW-1:0] out_cs_r;

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // Input register.
  logic                v0_r;
  logic [ENERGY_BITS-1:0] e0_r;
  logic [Z_BITS-1:0]   z0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (adv) begin
      v0_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e0_r <= in_energy_ev;
      z0_r <= in_atomic_number;
    end
  end

  // Charge-dependent amplitude of the correction term, as a constant table.
  logic [AW-1:0] a_tab [0:(2**Z_BITS)-1];
  for (genvar i = 0; i < 2**Z_BITS; i++) begin : g_atab
    assign a_tab[i] = AW'(((64'(700 + 5 * i) << F) + 64'd50000) / 64'd100000);
  end

  // Normalisation: leading one found, mantissa brought to Q1.30.
  logic [NW-1:0] n_nxt;
  logic [ENERGY_BITS+29:0] ext;

  always_comb begin
    n_nxt = '0;
    for (int i = 0; i < ENERGY_BITS; i++) begin
      if (e0_r[i]) n_nxt = NW'(i);
    end
  end

  assign ext = {e0_r, 30'd0} >> n_nxt;

  // Squaring stages; index 0 holds the normalised mantissa.
  logic          sq_v_r [0:30];
  logic [30:0]   sq_m_r [0:30];
  logic [29:0]   sq_f_r [0:30];
  logic [NW-1:0] sq_n_r [0:30];
  logic          sq_z_r [0:30];
  logic [AW-1:0] sq_a_r [0:30];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r[0] <= 1'b0;
    end else if (adv) begin
      sq_v_r[0] <= v0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_m_r[0] <= ext[30:0];
      sq_f_r[0] <= '0;
      sq_n_r[0] <= n_nxt;
      sq_z_r[0] <= (e0_r == '0);
      sq_a_r[0] <= a_tab[z0_r];
    end
  end

  for (genvar i = 1; i <= 30; i++) begin : g_sq
    logic [61:0] prod;
    logic [31:0] mm;
    assign prod = 62'(sq_m_r[i-1]) * 62'(sq_m_r[i-1]);
    assign mm   = prod[61:30];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[i] <= 1'b0;
      end else if (adv) begin
        sq_v_r[i] <= sq_v_r[i-1];
      end
    end

    // A square of two or more yields the next log fraction bit.
    always_ff @(posedge clk) begin
      if (adv) begin
        sq_m_r[i] <= mm[31] ? mm[31:1] : mm[30:0];
        sq_f_r[i] <= sq_f_r[i-1] | (mm[31] ? (30'd1 << (30 - i)) : 30'd0);
        sq_n_r[i] <= sq_n_r[i-1];
        sq_z_r[i] <= sq_z_r[i-1];
        sq_a_r[i] <= sq_a_r[i-1];
      end
    end
  end

  // Natural log at 30 fraction bits.
  logic [LNW-1:0] nl;
  logic [60:0]    fprod;
  logic           ln_v_r;
  logic [LNW-1:0] ln_r;
  logic           ln_z_r;
  logic [AW-1:0]  ln_a_r;

  assign nl    = LNW'(sq_n_r[30]) * LNW'(LN2_Q30);
  assign fprod = 61'(sq_f_r[30]) * 61'(LN2_Q30) + (61'd1 << 29);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ln_v_r <= 1'b0;
    end else if (adv) begin
      ln_v_r <= sq_v_r[30];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ln_r   <= nl + LNW'(fprod[60:30]);
      ln_z_r <= sq_z_r[30];
      ln_a_r <= sq_a_r[30];
    end
  end

  // L: subtract ln of the mass, round to Q4.F, clamp at both ends.
  logic [LNW-1:0] ld;
  logic [LNW-1:0] lr;
  logic [LW-1:0]  l_nxt;

  assign ld = ln_r - LNW'(LN_MASS_Q30);
  assign lr = (ld + LNW'(64'd1 << (29 - F))) >> (30 - F);

  always_comb begin
    if (ln_z_r || (ln_r <= LNW'(LN_MASS_Q30))) begin
      l_nxt = '0;
    end else if (lr > LNW'(LMAX)) begin
      l_nxt = LW'(LMAX);
    end else begin
      l_nxt = lr[LW-1:0];
    end
  end

  // Horner stages; index 0 holds L and the leading coefficient.
  logic                 h_v_r  [0:5];
  logic signed [XW-1:0] h_x_r  [0:5];
  logic [LW-1:0]        h_l_r  [0:5];
  logic [AW-1:0]        h_a_r  [0:5];
  logic [VW-1:0]        h_dd_r [1:5];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_v_r[0] <= 1'b0;
    end else if (adv) begin
      h_v_r[0] <= ln_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      h_x_r[0] <= XW'(micro_to_q(POLY_MICRO[5], F));
      h_l_r[0] <= l_nxt;
      h_a_r[0] <= ln_a_r;
    end
  end

  for (genvar j = 1; j <= 5; j++) begin : g_horner
    localparam logic signed [XW-1:0] CK = XW'(micro_to_q(POLY_MICRO[5-j], F));
    logic                 x_neg;
    logic [XW-2:0]        mag;
    logic [XW+LW-1:0]     pr;
    logic signed [XW-1:0] ps;
    logic signed [XW-1:0] sx;
    logic [VW-1:0]        dd;

    assign x_neg = h_x_r[j-1][XW-1];
    assign mag   = x_neg ? (XW-1)'(-h_x_r[j-1]) : (XW-1)'(h_x_r[j-1]);
    assign pr    = (XW+LW)'(mag) * (XW+LW)'(h_l_r[j-1]) + (XW+LW)'(HALF);
    assign ps    = signed'(XW'(pr >> F));
    assign sx    = x_neg ? -ps : ps;

    // The Gaussian argument (7.6 - L)^2 is formed alongside the first step.
    if (j == 1) begin : g_dd
      logic [LW-1:0]   dl;
      logic [2*LW:0]   dsq;
      assign dl  = (h_l_r[0] > LW'(C76)) ? h_l_r[0] - LW'(C76) : LW'(C76) - h_l_r[0];
      assign dsq = (2*LW+1)'(dl) * (2*LW+1)'(dl) + (2*LW+1)'(HALF);
      assign dd  = VW'(dsq >> F);
    end else begin : g_ddp
      assign dd = h_dd_r[j-1];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        h_v_r[j] <= 1'b0;
      end else if (adv) begin
        h_v_r[j] <= h_v_r[j-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        h_x_r[j]  <= sx + CK;
        h_l_r[j]  <= h_l_r[j-1];
        h_a_r[j]  <= h_a_r[j-1];
        h_dd_r[j] <= dd;
      end
    end
  end

  // Two exp units run side by side with the same latency.
  logic          x_pos;
  logic [VW-1:0] x_arg;
  logic          ex_vld;
  logic [EXW-1:0] ex_val;
  logic          ex_pos;
  logic          eg_vld;
  logic [EXW-1:0] eg_val;
  logic [AW-1:0] eg_a;

  assign x_pos = (h_x_r[5] > 0);
  assign x_arg = x_pos ? VW'(h_x_r[5]) : '0;

  hecs_exp_neg #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_BITS (1)
  ) u_exp_x (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (h_v_r[5]),
    .in_arg   (x_arg),
    .in_side  (x_pos),
    .out_vld  (ex_vld),
    .out_val  (ex_val),
    .out_side (ex_pos)
  );

  hecs_exp_neg #(
    .FRAC_BITS (FRAC_BITS),
    .SIDE_BITS (AW)
  ) u_exp_g (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (h_v_r[5]),
    .in_arg   (h_dd_r[5]),
    .in_side  (h_a_r[5]),
    .out_vld  (eg_vld),
    .out_val  (eg_val),
    .out_side (eg_a)
  );

  // Final products: 1 - exp(-x), the correction factor, its square, result.
  logic [AW+EXW:0] agp;
  logic           f1_v_r;
  logic [EXW-1:0] f1_om_r;
  logic [F:0]     f1_w_r;

  assign agp = (AW+EXW+1)'(eg_a) * (AW+EXW+1)'(eg_val) + (AW+EXW+1)'(HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_v_r <= 1'b0;
    end else if (adv) begin
      f1_v_r <= ex_vld && eg_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_om_r <= ex_pos ? EXW'(ONE) - ex_val : '0;
      f1_w_r  <= (F+1)'(ONE) + (F+1)'(agp >> F);
    end
  end

  logic [2*F+2:0] w2p;
  logic           f2_v_r;
  logic [EXW-1:0] f2_om_r;
  logic [F+1:0]   f2_w2_r;

  assign w2p = (2*F+3)'(f1_w_r) * (2*F+3)'(f1_w_r) + (2*F+3)'(HALF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_v_r <= 1'b0;
    end else if (adv) begin
      f2_v_r <= f1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_om_r <= f1_om_r;
      f2_w2_r <= (F+2)'(w2p >> F);
    end
  end

  logic [2*F+5:0] rp;
  logic [F+5:0]   res;

  assign rp  = ((2*F+6)'(f2_om_r) * (2*F+6)'(f2_w2_r) << 2) + (2*F+6)'(HALF);
  assign res = (F+6)'(rp >> F);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_cs_r <= (res > (F+6)'(5 * ONE)) ? OW'(5 * ONE) : OW'(res);
    end
  end

  assign out_valid         = out_valid_r;
  assign out_charge_square = out_cs_r;

  // The two exp units must stay in step.
  a_exp_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    ex_vld == eg_vld)
    else $error("exp units out of step");

  a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ex_vld |-> ex_val <= EXW'(ONE)) and (eg_vld |-> eg_val <= EXW'(ONE)))
    else $error("exp result above one");

  a_input_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v0_r)
    else $error("accepted beat lost at input register");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> $stable(h_x_r[5]) && $stable(f2_w2_r))
    else $error("pipeline moved during stall");

  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_cs_r <= OW'(5 * ONE))
    else $error("result above saturation level");

endmodule
